/* hdl/mec_pkg.sv */
// Shared constants, gradient tables and handoff types for the escape-time colorizer.
package mec_pkg;

  localparam int COORD_W         = 64;
  localparam int COORD_FRAC_BITS = 60;
  localparam int HALF_W          = COORD_W / 2;
  localparam int ACC_W           = 2 * COORD_W;
  localparam int CNT_W           = 20;

  localparam logic [CNT_W-1:0]   MAX_ITER_RESET = CNT_W'(200000);

  // |component| >= 2 and |z|^2 >= 4 at the product scale
  localparam logic [COORD_W-1:0] ESC_LIM    = COORD_W'(2) << COORD_FRAC_BITS;
  localparam logic [ACC_W-1:0]   ESC_THRESH = ACC_W'(4) << (2 * COORD_FRAC_BITS);

  // 0.009 in Q0.32
  localparam int                 SCALE_W   = 26;
  localparam logic [SCALE_W-1:0] SCALE_Q32 = SCALE_W'(38654706);
  localparam int                 FRAC_W    = 32;

  localparam int GRADIENT_STOPS = 7;
  localparam int IDX_W          = $clog2(GRADIENT_STOPS);
  localparam int POS_W          = FRAC_W + 1;
  localparam int CH_W           = 8;
  localparam int NUM_CH         = 3;
  localparam int T_FRAC         = 16;
  localparam int T_W            = T_FRAC + 1;

  localparam logic [POS_W-1:0] STOP_POS [GRADIENT_STOPS] = '{
    33'd0, 33'd343597384, 33'd644245094, 33'd1116691497,
    33'd1889785610, 33'd3006477107, 33'd4294967296
  };

  // rows: red, green, blue
  localparam logic [CH_W-1:0] STOP_RGB [NUM_CH][GRADIENT_STOPS] = '{
    '{8'd185, 8'd185, 8'd213, 8'd226, 8'd69,  8'd75,  8'd185},
    '{8'd210, 8'd101, 8'd19,  8'd141, 8'd45,  8'd92,  8'd210},
    '{8'd241, 8'd35,  8'd88,  8'd193, 8'd176, 8'd218, 8'd241}
  };

  // one partial product request to the shared multiplier
  typedef struct packed {
    logic       issue;
    logic       clear;
    logic [1:0] part;
  } mec_mul_req_t;

  // finished iteration handed to the colorizer
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             in_set;
  } mec_res_t;

endpackage

/* hdl/mec_mul.sv */
// Shared 32x32 multiplier with a 128-bit accumulator for 64x64 products.
module mec_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  mec_pkg::mec_mul_req_t         req,
  input  logic [mec_pkg::COORD_W-1:0]   a,
  input  logic [mec_pkg::COORD_W-1:0]   b,
  output logic [mec_pkg::ACC_W-1:0]     acc
);

  logic [mec_pkg::HALF_W-1:0]  a_half;
  logic [mec_pkg::HALF_W-1:0]  b_half;
  logic [mec_pkg::COORD_W-1:0] prod;
  mec_pkg::mec_mul_req_t       req_q;
  logic [mec_pkg::ACC_W-1:0]   addend;
  logic [mec_pkg::ACC_W-1:0]   acc_base;

  // part bit 1 picks the high half of a, bit 0 the high half of b
  assign a_half = req.part[1] ? a[mec_pkg::COORD_W-1:mec_pkg::HALF_W] : a[mec_pkg::HALF_W-1:0];
  assign b_half = req.part[0] ? b[mec_pkg::COORD_W-1:mec_pkg::HALF_W] : b[mec_pkg::HALF_W-1:0];

  always_comb begin
    case (req_q.part)
      2'd0:    addend = {{mec_pkg::COORD_W{1'b0}}, prod};
      2'd3:    addend = {prod, {mec_pkg::COORD_W{1'b0}}};
      default: addend = {{mec_pkg::HALF_W{1'b0}}, prod, {mec_pkg::HALF_W{1'b0}}};
    endcase
    acc_base = req_q.clear ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q <= '0;
    end else begin
      req_q <= req;
    end
    if (req.issue) begin
      prod <= mec_pkg::COORD_W'(a_half * b_half);
    end
    if (req_q.issue) begin
      acc <= acc_base + addend;
    end
  end

endmodule

/* hdl/mec_iter.sv */
// Sequencer for z = z*z + c steps and the escape test on the shared multiplier.
module mec_iter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mec_pkg::COORD_W-1:0]   c_real,
  input  logic [mec_pkg::COORD_W-1:0]   c_imag,
  input  logic [mec_pkg::CNT_W-1:0]     iter_limit,
  output logic                          res_valid,
  input  logic                          res_ready,
  output mec_pkg::mec_res_t             res,
  output mec_pkg::mec_mul_req_t         mul_req,
  output logic [mec_pkg::COORD_W-1:0]   mul_a,
  output logic [mec_pkg::COORD_W-1:0]   mul_b,
  input  logic [mec_pkg::ACC_W-1:0]     mul_acc
);

  localparam int F = mec_pkg::COORD_FRAC_BITS;
  localparam int W = mec_pkg::COORD_W;

  typedef enum logic [6:0] {
    I_IDLE   = 7'b0000001,
    I_CHECK  = 7'b0000010,
    I_MUL    = 7'b0000100,
    I_DRAIN  = 7'b0001000,
    I_UPDATE = 7'b0010000,
    I_MAG    = 7'b0100000,
    I_DONE   = 7'b1000000
  } istate_t;

  // which product is being built
  typedef enum logic [2:0] {
    P_RR    = 3'd0,
    P_II    = 3'd1,
    P_RI    = 3'd2,
    P_SUM_R = 3'd3,
    P_SUM_I = 3'd4
  } prod_sel_t;

  istate_t                 state;
  prod_sel_t               pidx;
  logic [1:0]              part;
  logic                    drain;
  logic [W-1:0]            cr, ci, zr, zi, mr, mi, sr, sdiff, q;
  logic [mec_pkg::CNT_W-1:0] count;
  logic                    ovf;

  logic [W-1:0] prod_hi;
  logic [W-1:0] q_raw;
  logic         q_neg;
  logic         q_low;
  logic [W-1:0] nr, ni;
  logic [W-1:0] zr_mag, zi_mag;

  assign in_ready  = (state == I_IDLE);
  assign res_valid = (state == I_DONE);
  assign res.count  = count;
  assign res.in_set = (count >= iter_limit);

  always_comb begin
    mul_req.issue = (state == I_MUL);
    mul_req.clear = (part == 2'd0) && (pidx != P_SUM_I);
    mul_req.part  = part;
    case (pidx)
      P_II, P_SUM_I: begin
        mul_a = mi;
        mul_b = mi;
      end
      P_RI: begin
        mul_a = mr;
        mul_b = mi;
      end
      default: begin
        mul_a = mr;
        mul_b = mr;
      end
    endcase
  end

  always_comb begin
    prod_hi = mul_acc[F+W-1:F];
    q_raw   = mul_acc[F+W-2:F-1];
    q_low   = (mul_acc[F-2:0] != '0);
    q_neg   = zr[W-1] ^ zi[W-1];
    nr      = sdiff + cr;
    ni      = q + ci;
    zr_mag  = zr[W-1] ? (~zr + W'(1)) : zr;
    zi_mag  = zi[W-1] ? (~zi + W'(1)) : zi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= I_IDLE;
      pidx  <= P_RR;
      part  <= 2'd0;
      drain <= 1'b0;
    end else begin
      case (state)
        I_IDLE: begin
          if (in_valid) begin
            cr    <= c_real;
            ci    <= c_imag;
            zr    <= '0;
            zi    <= '0;
            mr    <= '0;
            mi    <= '0;
            count <= '0;
            state <= I_CHECK;
          end
        end
        I_CHECK: begin
          if (count == iter_limit) begin
            state <= I_DONE;
          end else begin
            count <= count + mec_pkg::CNT_W'(1);
            pidx  <= P_RR;
            part  <= 2'd0;
            state <= I_MUL;
          end
        end
        I_MUL: begin
          part <= part + 2'd1;
          if (part == 2'd3) begin
            if (pidx == P_SUM_R) begin
              pidx <= P_SUM_I;
            end else begin
              drain <= 1'b0;
              state <= I_DRAIN;
            end
          end
        end
        I_DRAIN: begin
          // first cycle lets the last partial product land in the accumulator
          if (!drain) begin
            drain <= 1'b1;
          end else begin
            drain <= 1'b0;
            case (pidx)
              P_RR: begin
                sr    <= prod_hi;
                pidx  <= P_II;
                state <= I_MUL;
              end
              P_II: begin
                sdiff <= sr - prod_hi;
                pidx  <= P_RI;
                state <= I_MUL;
              end
              P_RI: begin
                // floor toward minus infinity for a negative cross term
                if (q_neg) begin
                  q <= q_low ? ~q_raw : (~q_raw + W'(1));
                end else begin
                  q <= q_raw;
                end
                state <= I_UPDATE;
              end
              P_SUM_I: begin
                state <= (mul_acc >= mec_pkg::ESC_THRESH) ? I_DONE : I_CHECK;
              end
              default: begin
                state <= I_DONE;
              end
            endcase
          end
        end
        I_UPDATE: begin
          zr    <= nr;
          zi    <= ni;
          ovf   <= ((~(sdiff ^ cr)) & (sdiff ^ nr) & {W{1'b1}}) != '0 &&
                   ((~(sdiff[W-1] ^ cr[W-1])) & (sdiff[W-1] ^ nr[W-1])) ||
                   ((~(q[W-1] ^ ci[W-1])) & (q[W-1] ^ ni[W-1]));
          state <= I_MAG;
        end
        I_MAG: begin
          mr <= zr_mag;
          mi <= zi_mag;
          if (ovf || zr_mag >= mec_pkg::ESC_LIM || zi_mag >= mec_pkg::ESC_LIM) begin
            state <= I_DONE;
          end else begin
            pidx  <= P_SUM_R;
            part  <= 2'd0;
            state <= I_MUL;
          end
        end
        I_DONE: begin
          if (res_ready) begin
            state <= I_IDLE;
          end
        end
        default: begin
          state <= I_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/mec_color.sv */
// Gradient lookup: count scaling, segment search, serial divide for t, channel blend.
module mec_color (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mec_pkg::mec_res_t             res,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mec_pkg::CNT_W-1:0]     iteration_count,
  output logic                          inside_set,
  output logic [mec_pkg::CH_W-1:0]      red,
  output logic [mec_pkg::CH_W-1:0]      green,
  output logic [mec_pkg::CH_W-1:0]      blue
);

  localparam int POS_W   = mec_pkg::POS_W;
  localparam int IDX_W   = mec_pkg::IDX_W;
  localparam int T_W     = mec_pkg::T_W;
  localparam int DCNT_W  = $clog2(T_W);
  localparam int PROD_W  = mec_pkg::CNT_W + mec_pkg::SCALE_W;
  localparam int MIX_W   = T_W + mec_pkg::CH_W + 2;

  typedef enum logic [6:0] {
    C_IDLE  = 7'b0000001,
    C_SCALE = 7'b0000010,
    C_SEG   = 7'b0000100,
    C_PREP  = 7'b0001000,
    C_DIV   = 7'b0010000,
    C_MIX   = 7'b0100000,
    C_OUT   = 7'b1000000
  } cstate_t;

  cstate_t                      state;
  logic [mec_pkg::FRAC_W-1:0]   fr;
  logic [IDX_W-1:0]             seg;
  logic [IDX_W-1:0]             seg_found;
  logic [IDX_W-1:0]             seg_up;
  logic [POS_W-1:0]             span;
  logic [POS_W-1:0]             rem;
  logic [POS_W:0]               trial;
  logic [T_W-1:0]               quo;
  logic [DCNT_W-1:0]            dcnt;
  logic [1:0]                   ch;
  logic [PROD_W-1:0]            scale_prod;
  logic [POS_W-1:0]             fr_ext;
  logic [mec_pkg::CH_W-1:0]     col_a, col_b;
  logic signed [mec_pkg::CH_W:0] col_diff;
  logic signed [MIX_W-1:0]      mix_prod;
  logic signed [MIX_W-1:0]      mix_sum;
  logic [mec_pkg::CH_W-1:0]     mix_val;

  assign in_ready  = (state == C_IDLE);
  assign out_valid = (state == C_OUT);

  assign scale_prod = PROD_W'(iteration_count) * PROD_W'(mec_pkg::SCALE_Q32);
  assign fr_ext     = {1'b0, fr};
  assign seg_up     = seg + IDX_W'(1);
  assign trial      = (dcnt == '0) ? {1'b0, rem} : {rem, 1'b0};

  // first segment whose upper stop reaches fr
  always_comb begin
    seg_found = IDX_W'(mec_pkg::GRADIENT_STOPS - 2);
    for (int k = mec_pkg::GRADIENT_STOPS - 2; k >= 0; k--) begin
      if (mec_pkg::STOP_POS[k+1] >= fr_ext) begin
        seg_found = IDX_W'(k);
      end
    end
  end

  always_comb begin
    col_a    = mec_pkg::STOP_RGB[ch][seg];
    col_b    = mec_pkg::STOP_RGB[ch][seg_up];
    col_diff = $signed({1'b0, col_b}) - $signed({1'b0, col_a});
    mix_prod = $signed({1'b0, quo}) * col_diff;
    mix_sum  = $signed({{(MIX_W - mec_pkg::CH_W - mec_pkg::T_FRAC){1'b0}}, col_a,
                        {mec_pkg::T_FRAC{1'b0}}}) + mix_prod;
    mix_val  = mix_sum[mec_pkg::T_FRAC + mec_pkg::CH_W - 1:mec_pkg::T_FRAC];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      case (state)
        C_IDLE: begin
          if (in_valid) begin
            iteration_count <= res.count;
            inside_set      <= res.in_set;
            if (res.in_set) begin
              red   <= '0;
              green <= '0;
              blue  <= '0;
              state <= C_OUT;
            end else begin
              state <= C_SCALE;
            end
          end
        end
        C_SCALE: begin
          fr    <= scale_prod[mec_pkg::FRAC_W-1:0];
          state <= C_SEG;
        end
        C_SEG: begin
          seg   <= seg_found;
          state <= C_PREP;
        end
        C_PREP: begin
          span  <= mec_pkg::STOP_POS[seg_up] - mec_pkg::STOP_POS[seg];
          rem   <= (fr_ext > mec_pkg::STOP_POS[seg]) ? (fr_ext - mec_pkg::STOP_POS[seg]) : '0;
          quo   <= '0;
          dcnt  <= '0;
          state <= C_DIV;
        end
        C_DIV: begin
          // one quotient bit per cycle, restoring
          if (trial >= {1'b0, span}) begin
            rem <= POS_W'(trial - {1'b0, span});
            quo <= {quo[T_W-2:0], 1'b1};
          end else begin
            rem <= POS_W'(trial);
            quo <= {quo[T_W-2:0], 1'b0};
          end
          dcnt <= dcnt + DCNT_W'(1);
          if (dcnt == DCNT_W'(T_W - 1)) begin
            ch    <= 2'd0;
            state <= C_MIX;
          end
        end
        C_MIX: begin
          case (ch)
            2'd0:    red   <= mix_val;
            2'd1:    green <= mix_val;
            default: blue  <= mix_val;
          endcase
          ch <= ch + 2'd1;
          if (ch == 2'(mec_pkg::NUM_CH - 1)) begin
            state <= C_OUT;
          end
        end
        C_OUT: begin
          if (out_ready) begin
            state <= C_IDLE;
          end
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/mandelbrot_escape_colorizer.sv */
// Top level: escape-time iteration of one point and gradient coloring of the count.
//
// A point c enters on the slave stream as one 128-bit word (c_real low, c_imag high,
// both signed Q4.60). The result leaves on the master stream: iteration count and
// the 8-bit red, green and blue channels in tdata, the inside flag in tuser.
// The iteration limit is written through the cfg channel and resets to 200000.
//
// One item at a time: s_axis_tready is high only while the iteration sequencer is
// idle. Each iteration step runs on the single 32x32 multiplier that builds five
// 64x64 products as four partial products each; the |z|^2 products are skipped when
// a component alone escapes. Coloring follows, with a bit-serial divide for the
// blend fraction; inside points skip coloring.
// The colorizer holds its result while m_axis_tready is low; the sequencer may
// finish the next point meanwhile and then waits for the colorizer to free up.
// Reset returns both sequencers to idle, drops m_axis_tvalid and restores the limit.
module mandelbrot_escape_colorizer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // c_real[63:0], c_imag[127:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,   // iteration_count[19:0], red[27:20],
                                       // green[35:28], blue[43:36], zero[47:44]
  output logic         m_axis_tuser,   // inside_set[0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [19:0]  cfg_data        // iteration limit
);

  logic [mec_pkg::CNT_W-1:0]  iter_limit;
  mec_pkg::mec_mul_req_t      mul_req;
  logic [mec_pkg::COORD_W-1:0] mul_a, mul_b;
  logic [mec_pkg::ACC_W-1:0]  mul_acc;
  logic                       res_valid, res_ready;
  mec_pkg::mec_res_t          res;
  logic [mec_pkg::CNT_W-1:0]  iteration_count;
  logic                       inside_set;
  logic [mec_pkg::CH_W-1:0]   red, green, blue;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      iter_limit <= mec_pkg::MAX_ITER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      iter_limit <= cfg_data;
    end
  end

  mec_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .a   (mul_a),
    .b   (mul_b),
    .acc (mul_acc)
  );

  mec_iter u_iter (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .c_real         (s_axis_tdata[63:0]),
    .c_imag         (s_axis_tdata[127:64]),
    .iter_limit     (iter_limit),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res),
    .mul_req        (mul_req),
    .mul_a          (mul_a),
    .mul_b          (mul_b),
    .mul_acc        (mul_acc)
  );

  mec_color u_color (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (res_valid),
    .in_ready        (res_ready),
    .res             (res),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .iteration_count (iteration_count),
    .inside_set      (inside_set),
    .red             (red),
    .green           (green),
    .blue            (blue)
  );

  assign m_axis_tdata = {4'b0000, blue, green, red, iteration_count};
  assign m_axis_tuser = inside_set;

  a_inside_black: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[43:20] == '0)
    else $error("inside point carries a nonzero color");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("new point accepted while iterating");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result word presented right after reset");

endmodule
